// File: hdl/substring_distinct_subsequence_count_top_defines.svh
// Assertion macros shared by the RTL.
`ifndef SUBSTRING_DISTINCT_SUBSEQUENCE_COUNT_TOP_DEFINES_SVH
`define SUBSTRING_DISTINCT_SUBSEQUENCE_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SDSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SDSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sdsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

  typedef logic [3:0]  letter_t;
  typedef logic [29:0] count_t;
  typedef logic [31:0] wide_t;

  localparam letter_t NUM_LETTERS = 4'd9;
  localparam count_t  MODULUS     = 30'd1000000007;
  localparam wide_t   MODULUS_W   = 32'd1000000007;
  localparam wide_t   MODULUS_2W  = 32'd2000000014;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic    clear;
    logic    step;
    letter_t letter;
  } acc_ctl_t;

endpackage

`default_nettype wire

// File: hdl/substring_distinct_subsequence_count_top.sv
// Write transaction: stored in the cycle after acceptance, no result.
// Query over L letters: ST_WALK reads them, then ST_TAIL, ST_FIN; empty range goes to ST_FIN directly.
// A new query waits until the last one is done; one letter per cycle from the single read port.
// Input stalls while a query is in flight; a finished result waits in the output register.
// Reset (rst_n, synchronous, low) clears control only; store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "substring_distinct_subsequence_count_top_defines.svh"

module substring_distinct_subsequence_count_top #(
  parameter int MAX_LEN = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  sdsc_pkg::letter_t in_letter,
  input  logic [9:0]       in_start_req,
  input  logic [9:0]       in_stop,
  output logic             out_valid,
  input  logic             out_stall,
  output sdsc_pkg::count_t  out_count
);
  import sdsc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_TAIL, ST_FIN} state_t;

  state_t        state_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] last_r;
  letter_t       rd_data_r;
  logic          dv_r;
  logic          out_valid_r;
  count_t        out_count_r;
  letter_t       mem [MAX_LEN];

  logic [CW-1:0] start_ext;
  logic [CW-1:0] stop_ext;
  logic [CW-1:0] last_c;
  logic          accept;
  logic          wr_en;
  logic          query;
  logic          empty;
  acc_ctl_t      acc_ctl;
  count_t        acc_count;

  always_comb begin
    start_ext = CW'(in_start_req);
    stop_ext  = CW'(in_stop);
    last_c    = (stop_ext >= CW'(MAX_LEN)) ? CW'(MAX_LEN - 1) : stop_ext;
    empty     = start_ext > last_c;
    accept    = in_valid && !in_stall;
    query     = accept && (in_func == FUNC_QUERY);
    wr_en     = accept && (in_func == FUNC_WRITE) && (start_ext < CW'(MAX_LEN)) &&
                (in_letter < NUM_LETTERS);
    acc_ctl.clear  = query;
    acc_ctl.step   = dv_r;
    acc_ctl.letter = rd_data_r;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[start_ext[AW-1:0]] <= in_letter;
    end
    if (state_r == ST_WALK) begin
      rd_data_r <= mem[addr_r];
    end
  end

  sdsc_acc u_acc (
    .clk   (clk),
    .ctl   (acc_ctl),
    .count (acc_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r <= state_r == ST_WALK;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (query) begin
            addr_r  <= start_ext[AW-1:0];
            last_r  <= last_c[AW-1:0];
            state_r <= empty ? ST_FIN : ST_WALK;
          end
        end
        ST_WALK: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == last_r) begin
            state_r <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_count_r <= acc_count;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `SDSC_ASSERT_NOW(a_load_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "result not from finish")
  `SDSC_ASSERT_NOW(a_count_range, out_valid_r, out_count_r < MODULUS, "count not reduced")
  `SDSC_ASSERT_NOW(a_walk_bound, state_r == ST_WALK, addr_r <= last_r, "walk passed range end")
  `SDSC_ASSERT_NOW(a_dv_phase, dv_r, state_r == ST_WALK || state_r == ST_TAIL, "stray read data")
  `SDSC_ASSERT_NEXT(a_tail_fin, state_r == ST_TAIL, state_r == ST_FIN, "tail did not finish")

endmodule

`default_nettype wire

// File: hdl/sdsc_acc.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsc_acc (
  input  logic              clk,
  input  sdsc_pkg::acc_ctl_t ctl,
  output sdsc_pkg::count_t   count
);
  import sdsc_pkg::*;

  // total_r is the sum of the nine letter counters plus the empty counter, which stays 1.
  count_t ctr_r [NUM_LETTERS];
  count_t total_r;
  count_t old;
  count_t total_nxt;
  wide_t  u;
  logic   hit;

  always_comb begin
    hit = ctl.letter < NUM_LETTERS;
    old = hit ? ctr_r[ctl.letter] : '0;
    // 2*total - old + P, then fold back below P
    u = {1'b0, total_r, 1'b0} + MODULUS_W - {2'b00, old};
    if (u >= MODULUS_2W) begin
      total_nxt = count_t'(u - MODULUS_2W);
    end else if (u >= MODULUS_W) begin
      total_nxt = count_t'(u - MODULUS_W);
    end else begin
      total_nxt = count_t'(u);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      total_r <= 30'd1;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        ctr_r[i] <= '0;
      end
    end else if (ctl.step && hit) begin
      ctr_r[ctl.letter] <= total_r;
      total_r           <= total_nxt;
    end
  end

  assign count = (total_r == '0) ? (MODULUS - 30'd1) : (total_r - 30'd1);

endmodule

`default_nettype wire
